// ----- sv/swcr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swcr_pkg
// Shared constants and types for the shallow-water cell rate block.
// ----------------------------------------------------------------------------
package swcr_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int ACC_W   = 34;
    localparam int SIZE_W  = 31;
    localparam int CELL_W  = 20;
    localparam int OP_W    = 3;
    localparam int OUT_W   = 32;
    localparam int IDX_W   = 1;

    localparam logic [OP_W-1:0] OP_WEST  = 3'd0;
    localparam logic [OP_W-1:0] OP_EAST  = 3'd1;
    localparam logic [OP_W-1:0] OP_SOUTH = 3'd2;
    localparam logic [OP_W-1:0] OP_NORTH = 3'd3;
    localparam logic [OP_W-1:0] OP_CELL  = 3'd4;

    localparam logic [IDX_W-1:0] REG_SIZE_X = 1'b0;
    localparam logic [IDX_W-1:0] REG_SIZE_Y = 1'b1;

    // divider command / status between sequencer and divider
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [SIZE_W-1:0] divisor;
    } div_cmd_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quotient;
    } div_sts_t;

endpackage

// ----- sv/swcr_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swcr_div
// Radix-2 restoring divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module swcr_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  swcr_pkg::div_cmd_t  cmd,
    output swcr_pkg::div_sts_t  sts
);
    localparam int NB = 64;
    localparam int RW = swcr_pkg::SIZE_W + 1;

    logic [NB-1:0] quo_reg, quo_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [swcr_pkg::SIZE_W-1:0] den_reg, den_next;
    logic [6:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next, done_reg, done_next;
    logic [RW:0] trial;
    logic [RW-1:0] shifted;

    // one restoring step per cycle
    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[RW-2:0], quo_reg[NB-1]};
        trial     = {1'b0, shifted} - {2'b00, den_reg};
        if (cmd.start) begin
            quo_next  = cmd.dividend;
            rem_next  = '0;
            den_next  = (cmd.divisor == '0) ? swcr_pkg::SIZE_W'(1) : cmd.divisor;
            cnt_next  = 7'(NB);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[RW]) begin
                rem_next = trial[RW-1:0];
                quo_next = {quo_reg[NB-2:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[NB-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign sts.busy     = busy_reg;
    assign sts.done     = done_reg;
    assign sts.quotient = quo_reg;

    // done only follows a busy cycle
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg)) else $error("done without busy");
    // no restart while busy
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !cmd.start) else $error("divider restarted while busy");
    // busy clears only through done
    a_busy_fall: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(busy_reg) |-> done_reg) else $error("busy fell without done");
endmodule

// ----- sv/shallow_water_cell_rate.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shallow_water_cell_rate
// Shallow-water cell derivative unit: face flux sums, shared divider.
// ----------------------------------------------------------------------------
// face transactions can follow back to back while the unit is idle
// a cell transaction runs ten divisions on one shared radix-2 divider, then
// four g products; the next input is accepted in the cycle after the result
// is taken
// the divider produces one quotient bit per cycle
// reset (synchronous, aresetn low) clears the sums, sizes to 1.0 and control
module shallow_water_cell_rate #(
    parameter int DATA_WIDTH = swcr_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = swcr_pkg::FRAC_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // tdata: flux_depth, flux_momentum_x, flux_momentum_y, flux_wall, depth,
    // depth_slope_x, depth_slope_y, bed_slope_x, bed_slope_y, cell_index
    input  logic [311:0]  s_tdata,
    // tuser: operation
    input  logic [2:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // tdata: result_cell, rate_depth, rate_momentum_x, rate_momentum_y
    output logic [119:0]  m_tdata,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_index,
    input  logic [30:0]   cfg_data
);
    localparam int ACC_W  = swcr_pkg::ACC_W;
    localparam int OUT_W  = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam logic [63:0] G_FIX = 64'(((64'd981 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [63:0] CLAMP = 64'd1 << 59;
    localparam int NJOB = 13;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_ISSUE = 5'b00010,
        ST_WAIT = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [30:0] size_x_reg, size_y_reg;
    logic signed [ACC_W-1:0] sum_reg [8];
    logic [3:0] job_reg;
    logic signed [71:0] dh_reg, du_reg, dv_reg;
    logic [30:0] depth_reg;
    logic signed [31:0] hx_reg, hy_reg, bx_reg, by_reg;
    logic [19:0] cell_reg;
    logic [95:0] res_reg;
    logic [63:0] prod_reg;
    logic prod_neg_reg;
    logic [1:0] mstep_reg;

    swcr_pkg::div_cmd_t dcmd;
    swcr_pkg::div_sts_t dsts;

    swcr_div u_div (.aclk(aclk), .aresetn(aresetn), .cmd(dcmd), .sts(dsts));

    logic [2:0] op;
    assign op = s_tuser;
    assign s_tready = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata = {4'b0, res_reg, cell_reg};

    // job order: 0..7 sum divisions (sums x use size_x), 8/9 bed limits
    // sum index: 0 depth_x 1 depth_y 2 mxx 3 mxy 4 myx 5 myy 6 wall_x 7 wall_y
    logic signed [ACC_W-1:0] cur_sum;
    logic [ACC_W-1:0] cur_abs;
    logic [63:0] cur_mag;
    logic cur_neg, cur_y;
    always_comb begin
        cur_sum = sum_reg[job_reg[2:0]];
        cur_y   = job_reg[0];
        cur_abs = '0;
        if (job_reg >= 4'd8) begin
            cur_neg = 1'b0;
            cur_mag = 64'(depth_reg) << FRAC_BITS;
        end else begin
            cur_neg = cur_sum[ACC_W-1];
            cur_abs = cur_neg ? ACC_W'(-cur_sum) : ACC_W'(cur_sum);
            cur_mag = 64'(cur_abs) << FRAC_BITS;
        end
        dcmd.start    = (state_reg == ST_ISSUE);
        dcmd.dividend = cur_mag;
        dcmd.divisor  = cur_y ? size_y_reg : size_x_reg;
    end

    // signed quotient, clamped
    logic [63:0] qmag;
    logic signed [71:0] qs;
    assign qmag = (dsts.quotient > CLAMP) ? CLAMP : dsts.quotient;
    assign qs = cur_neg ? -72'(qmag) : 72'(qmag);

    // bed slope clamped in magnitude to the limit quotient (job 8 x, job 9 y)
    logic signed [31:0] slope_cur, slope_lim;
    logic [31:0] slope_mag;
    always_comb begin
        slope_cur = job_reg[0] ? by_reg : bx_reg;
        slope_mag = slope_cur[31] ? 32'(-slope_cur) : 32'(slope_cur);
        if (64'(slope_mag) > qmag) slope_lim = slope_cur[31] ? -32'(qmag) : 32'(qmag);
        else slope_lim = slope_cur;
    end

    // multiply operand for the g products: 0 hx, 1 bx limited, 2 hy, 3 by limited
    logic signed [63:0] mop;
    logic [63:0] mmag;
    always_comb begin
        unique case (mstep_reg)
            2'd0: mop = 64'(hx_reg);
            2'd1: mop = 64'(bx_reg);
            2'd2: mop = 64'(hy_reg);
            2'd3: mop = 64'(by_reg);
        endcase
        mmag = mop[63] ? 64'(-mop) : 64'(mop);
    end

    // saturation
    function automatic logic [31:0] sat(input logic signed [71:0] v);
        logic signed [71:0] hi, lo;
        hi = (72'sd1 <<< (OUT_W - 1)) - 72'sd1;
        lo = -hi - 72'sd1;
        if (v > hi) sat = 32'(hi);
        else if (v < lo) sat = 32'(lo);
        else sat = 32'(v);
    endfunction

    logic signed [71:0] prod_s;
    assign prod_s = prod_neg_reg ? -72'(prod_reg >> FRAC_BITS) : 72'(prod_reg >> FRAC_BITS);

    logic s_acc;
    assign s_acc = s_tvalid && s_tready;

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_acc && op == swcr_pkg::OP_CELL) state_next = ST_ISSUE;
            ST_ISSUE: state_next = ST_WAIT;
            ST_WAIT:  if (dsts.done) state_next = (job_reg == 4'd9) ? ST_MUL : ST_ISSUE;
            ST_MUL:   if (mstep_reg == 2'd3 && job_reg == 4'(NJOB - 1)) state_next = ST_OUT;
            ST_OUT:   if (m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            size_x_reg <= 31'd65536;
            size_y_reg <= 31'd65536;
            for (int i = 0; i < 8; i++) sum_reg[i] <= '0;
            job_reg   <= '0;
            mstep_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == swcr_pkg::REG_SIZE_X) size_x_reg <= cfg_data;
                else size_y_reg <= cfg_data;
            end
            // face accumulation
            if (s_acc && op <= swcr_pkg::OP_NORTH) begin
                for (int k = 0; k < 4; k++) begin
                    logic signed [ACC_W-1:0] f;
                    f = ACC_W'(signed'(s_tdata[32*k +: 32]));
                    if (op[1]) sum_reg[2*k+1] <= op[0] ? sum_reg[2*k+1] - f : sum_reg[2*k+1] + f;
                    else       sum_reg[2*k]   <= op[0] ? sum_reg[2*k] - f   : sum_reg[2*k] + f;
                end
            end
            if (s_acc && op == swcr_pkg::OP_CELL) begin
                job_reg <= '0;
                mstep_reg <= '0;
            end
            if (state_reg == ST_WAIT && dsts.done && job_reg != 4'd9) job_reg <= job_reg + 4'd1;
            if (state_reg == ST_WAIT && dsts.done && job_reg == 4'd9) job_reg <= 4'd10;
            // three phases per product: multiply, accumulate, saturate into the result
            if (state_reg == ST_MUL) begin
                if (job_reg == 4'(NJOB - 1)) begin
                    job_reg <= 4'd10;
                    mstep_reg <= mstep_reg + 2'd1;
                end else job_reg <= job_reg + 4'd1;
            end
            if (state_reg == ST_OUT && m_tready)
                for (int i = 0; i < 8; i++) sum_reg[i] <= '0;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_acc && op == swcr_pkg::OP_CELL) begin
            depth_reg <= s_tdata[158:128];
            hx_reg <= s_tdata[190:159];
            hy_reg <= s_tdata[222:191];
            bx_reg <= s_tdata[254:223];
            by_reg <= s_tdata[286:255];
            cell_reg <= s_tdata[306:287];
            dh_reg <= '0; du_reg <= '0; dv_reg <= '0;
        end
        if (state_reg == ST_WAIT && dsts.done) begin
            unique case (job_reg)
                4'd0, 4'd1: dh_reg <= dh_reg + qs;
                4'd2, 4'd3, 4'd6: du_reg <= du_reg + qs;
                4'd4, 4'd5, 4'd7: dv_reg <= dv_reg + qs;
                4'd8: bx_reg <= slope_lim;
                4'd9: by_reg <= slope_lim;
                default: ;
            endcase
        end
        if (state_reg == ST_MUL) begin
            if (job_reg == 4'd10) begin
                prod_reg <= 64'(mmag[31:0]) * 64'(G_FIX[33:0]);
                prod_neg_reg <= mop[63];
            end else if (job_reg == 4'd11) begin
                if (mstep_reg[1]) dv_reg <= dv_reg - prod_s;
                else du_reg <= du_reg - prod_s;
            end else begin
                res_reg <= {sat(dv_reg), sat(du_reg), sat(dh_reg)};
            end
        end
    end

    a_out_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input open during output");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |=> sum_reg[0] == '0) else $error("sums not cleared");
endmodule

// ----- tb/shallow_water_cell_rate_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shallow_water_cell_rate_tb
// Self-checking bench: drives face and cell transactions with random gaps and
// stalls, predicts dh/dt, du/dt and dv/dt from its own flux sums and compares
// every result field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module shallow_water_cell_rate_tb;

    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam int unsigned DRAIN_WAIT  = 800;
    localparam int unsigned HOLD_CYCLES = 3000;
    localparam int FRAC = swcr_pkg::FRAC_BITS_DEF;
    localparam longint unsigned GRAV    = ((64'd981 << FRAC) + 64'd50) / 64'd100;

    typedef struct {
        logic [swcr_pkg::OP_W-1:0]   op;
        logic [31:0]                 fl_depth, fl_mom_x, fl_mom_y, fl_wall;
        logic [30:0]                 depth;
        logic [31:0]                 dslope_x, dslope_y, bslope_x, bslope_y;
        logic [swcr_pkg::CELL_W-1:0] tag;
    } cell_item_t;

    typedef struct {
        logic [swcr_pkg::CELL_W-1:0] tag;
        logic [31:0]                 rate_h, rate_u, rate_v;
    } cell_rate_t;

    logic          aclk = 1'b0;
    logic          aresetn;
    logic          s_tvalid, s_tready;
    logic [311:0]  s_tdata;
    logic [2:0]    s_tuser;
    logic          m_tvalid, m_tready;
    logic [119:0]  m_tdata;
    logic          cfg_valid, cfg_ready, cfg_index;
    logic [30:0]   cfg_data;

    // predictor state
    logic [30:0]   size_x, size_y;
    logic [33:0]   sum_h_x, sum_h_y, sum_u_x, sum_u_y, sum_v_x, sum_v_y, sum_w_x, sum_w_y;
    cell_rate_t    pending_rates[$];
    int unsigned   errors = 0;
    int unsigned   cycles = 0;
    bit            hold_req = 1'b0;
    bit            no_idle = 1'b0;

    shallow_water_cell_rate uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // clock
    initial begin
        forever #2 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL shallow_water_cell_rate");
            $finish;
        end
    end

    // ---------------- predictor ----------------
    function automatic longint flux_quot(logic [33:0] acc, logic [30:0] size);
        longint s;
        longint unsigned m, d, q;
        s = longint'($signed(acc));
        m = (s < 0) ? longint'(-s) : longint'(s);
        d = (size == 0) ? 64'd1 : 64'(size);
        q = (m << FRAC) / d;
        if (q > (64'd1 << 59)) q = 64'd1 << 59;
        return (s < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint times_g(longint a);
        longint unsigned m, hi, lo, r;
        m  = (a < 0) ? longint'(-a) : longint'(a);
        hi = m * (GRAV >> 16);
        lo = m * (GRAV & 64'hFFFF);
        r  = ((hi << 8) + (lo >> 8)) >> (FRAC - 8);
        return (a < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint limit_bed(logic [31:0] slope, logic [30:0] depth,
                                         logic [30:0] size);
        longint s;
        longint unsigned d, lim, m;
        s   = longint'($signed(slope));
        d   = (size == 0) ? 64'd1 : 64'(size);
        lim = (64'(depth) << FRAC) / d;
        m   = (s < 0) ? longint'(-s) : longint'(s);
        if (m > lim) return (s < 0) ? -longint'(lim) : longint'(lim);
        return s;
    endfunction

    function automatic logic [31:0] clip32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [33:0] acc_step(logic [33:0] acc, logic [31:0] f, bit sub);
        logic [33:0] ext;
        ext = {{2{f[31]}}, f};
        return sub ? acc - ext : acc + ext;
    endfunction

    task automatic clear_sums();
        {sum_h_x, sum_h_y, sum_u_x, sum_u_y, sum_v_x, sum_v_y, sum_w_x, sum_w_y} = '0;
    endtask

    task automatic predict_rates(cell_item_t it);
        bit sub;
        longint bed_x, bed_y, dh, du, dv;
        cell_rate_t r;
        sub = it.op[0];
        if (it.op == swcr_pkg::OP_WEST || it.op == swcr_pkg::OP_EAST) begin
            sum_h_x = acc_step(sum_h_x, it.fl_depth, sub);
            sum_u_x = acc_step(sum_u_x, it.fl_mom_x, sub);
            sum_v_x = acc_step(sum_v_x, it.fl_mom_y, sub);
            sum_w_x = acc_step(sum_w_x, it.fl_wall, sub);
        end else if (it.op == swcr_pkg::OP_SOUTH || it.op == swcr_pkg::OP_NORTH) begin
            sum_h_y = acc_step(sum_h_y, it.fl_depth, sub);
            sum_u_y = acc_step(sum_u_y, it.fl_mom_x, sub);
            sum_v_y = acc_step(sum_v_y, it.fl_mom_y, sub);
            sum_w_y = acc_step(sum_w_y, it.fl_wall, sub);
        end else if (it.op == swcr_pkg::OP_CELL) begin
            bed_x = limit_bed(it.bslope_x, it.depth, size_x);
            bed_y = limit_bed(it.bslope_y, it.depth, size_y);
            dh = flux_quot(sum_h_x, size_x) + flux_quot(sum_h_y, size_y);
            du = flux_quot(sum_u_x, size_x) + flux_quot(sum_u_y, size_y)
               - times_g(longint'($signed(it.dslope_x))) + flux_quot(sum_w_x, size_x)
               - times_g(bed_x);
            dv = flux_quot(sum_v_x, size_x) + flux_quot(sum_v_y, size_y)
               - times_g(longint'($signed(it.dslope_y))) + flux_quot(sum_w_y, size_y)
               - times_g(bed_y);
            r.tag = it.tag;
            r.rate_h = clip32(dh);
            r.rate_u = clip32(du);
            r.rate_v = clip32(dv);
            pending_rates.push_back(r);
            clear_sums();
        end
    endtask

    // ---------------- drivers ----------------
    function automatic int unsigned pick_gap();
        return no_idle ? 0 : $urandom_range(0, 13);
    endfunction

    task automatic send_item(cell_item_t it);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= {5'b0, it.tag, it.bslope_y, it.bslope_x, it.dslope_y, it.dslope_x,
                     it.depth, it.fl_wall, it.fl_mom_y, it.fl_mom_x, it.fl_depth};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_rates(it);
    endtask

    task automatic write_reg(logic idx, logic [30:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == swcr_pkg::REG_SIZE_X) size_x = value;
        else size_y = value;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_rates.size() != 0) @(posedge aclk);
        repeat (32) @(posedge aclk);
    endtask

    // receiver stalls, including one long hold-off on request
    initial begin
        int unsigned n;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                n = pick_gap();
                if (n > 0) begin
                    m_tready <= 1'b0;
                    repeat (n) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!(m_tvalid && m_tready) && !hold_req) @(posedge aclk);
        end
    end

    // result checker
    always @(posedge aclk) begin
        cell_rate_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_rates.size() == 0) begin
                $display("%0t: unexpected result cell=%h", $realtime, m_tdata[19:0]);
                errors++;
            end else begin
                exp_r = pending_rates.pop_front();
                if (m_tdata[19:0] !== exp_r.tag) begin
                    $display("%0t: result_cell exp %h act %h", $realtime, exp_r.tag,
                             m_tdata[19:0]);
                    errors++;
                end
                if (m_tdata[51:20] !== exp_r.rate_h) begin
                    $display("%0t: rate_depth exp %h act %h", $realtime, exp_r.rate_h,
                             m_tdata[51:20]);
                    errors++;
                end
                if (m_tdata[83:52] !== exp_r.rate_u) begin
                    $display("%0t: rate_momentum_x exp %h act %h", $realtime, exp_r.rate_u,
                             m_tdata[83:52]);
                    errors++;
                end
                if (m_tdata[115:84] !== exp_r.rate_v) begin
                    $display("%0t: rate_momentum_y exp %h act %h", $realtime, exp_r.rate_v,
                             m_tdata[115:84]);
                    errors++;
                end
            end
        end
    end

    // ---------------- stimulus helpers ----------------
    function automatic logic [31:0] rand_q(int unsigned mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
            2: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000);
        endcase
    endfunction

    function automatic cell_item_t rand_item(logic [swcr_pkg::OP_W-1:0] op);
        cell_item_t it;
        it.op       = op;
        it.fl_depth = rand_q($urandom_range(0, 3));
        it.fl_mom_x = rand_q($urandom_range(0, 3));
        it.fl_mom_y = rand_q($urandom_range(0, 3));
        it.fl_wall  = rand_q($urandom_range(0, 3));
        it.depth    = ($urandom_range(0, 1) != 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 20));
        it.dslope_x = rand_q($urandom_range(0, 3));
        it.dslope_y = rand_q($urandom_range(0, 3));
        it.bslope_x = rand_q($urandom_range(0, 3));
        it.bslope_y = rand_q($urandom_range(0, 3));
        it.tag      = 20'($urandom);
        return it;
    endfunction

    // one cell: four faces in order, occasionally with noise or a broken set
    task automatic send_cell_set();
        logic [swcr_pkg::OP_W-1:0] op;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) begin
                op = swcr_pkg::OP_W'($urandom_range(0, 7));
                send_item(rand_item(op));
            end
        end
        send_item(rand_item(swcr_pkg::OP_WEST));
        send_item(rand_item(swcr_pkg::OP_EAST));
        send_item(rand_item(swcr_pkg::OP_SOUTH));
        send_item(rand_item(swcr_pkg::OP_NORTH));
        send_item(rand_item(swcr_pkg::OP_CELL));
    endtask

    // ---------------- tests ----------------
    task automatic test_directed();
        cell_item_t it;
        it = rand_item(swcr_pkg::OP_WEST);
        it.fl_depth = 32'h7FFF_FFFF; it.fl_mom_x = 32'h7FFF_FFFF;
        it.fl_mom_y = 32'h8000_0000; it.fl_wall = 32'h7FFF_FFFF;
        send_item(it);
        it.op = swcr_pkg::OP_EAST;
        it.fl_depth = 32'h8000_0000; it.fl_mom_x = 32'h8000_0000;
        it.fl_mom_y = 32'h7FFF_FFFF; it.fl_wall = 32'h8000_0000;
        send_item(it);
        it.op = swcr_pkg::OP_SOUTH; send_item(it);
        it.op = swcr_pkg::OP_NORTH; send_item(it);
        // cell with extreme slopes and depth, max tag
        it.op = swcr_pkg::OP_CELL; it.depth = 31'h7FFF_FFFF; it.tag = 20'hFFFFF;
        it.dslope_x = 32'h8000_0000; it.dslope_y = 32'h7FFF_FFFF;
        it.bslope_x = 32'h7FFF_FFFF; it.bslope_y = 32'h8000_0000;
        send_item(it);
        // zero depth clamps bed slopes to zero, empty sums
        it.depth = '0; it.tag = '0;
        send_item(it);
        // unknown operations keep the sums
        send_item(rand_item(swcr_pkg::OP_WEST));
        send_item(rand_item(3'd5));
        send_item(rand_item(3'd6));
        send_item(rand_item(3'd7));
        send_item(rand_item(swcr_pkg::OP_CELL));
        // repeated faces push the sums to full scale without wrapping, missing faces
        repeat (4) begin
            it = rand_item(swcr_pkg::OP_WEST);
            it.fl_depth = 32'h7FFF_FFFF; it.fl_mom_x = 32'h8000_0000;
            send_item(it);
        end
        repeat (2) send_item(rand_item(swcr_pkg::OP_NORTH));
        send_item(rand_item(swcr_pkg::OP_CELL));
        send_item(rand_item(swcr_pkg::OP_SOUTH));
        send_item(rand_item(swcr_pkg::OP_CELL));
        wait_idle();
    endtask

    task automatic test_size_sweep();
        logic [30:0] sizes[6];
        sizes = '{31'h7FFF_FFFF, 31'd1, 31'd0, 31'h0001_0000, 31'h0000_8000, 31'($urandom)};
        foreach (sizes[i]) begin
            write_reg(swcr_pkg::REG_SIZE_X, sizes[i]);
            write_reg(swcr_pkg::REG_SIZE_Y, sizes[(i + 1) % 6]);
            repeat (20) send_cell_set();
            wait_idle();
        end
    endtask

    task automatic test_random_sets();
        write_reg(swcr_pkg::REG_SIZE_X, 31'($urandom_range(1, 1 << 20)));
        write_reg(swcr_pkg::REG_SIZE_Y, 31'($urandom_range(1, 1 << 20)));
        for (int i = 0; i < 90; i++) begin
            no_idle = (i >= 40 && i < 55);
            send_cell_set();
        end
        no_idle = 1'b0;
        wait_idle();
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (15) send_cell_set();
        wait_idle();
    endtask

    // ---------------- main ----------------
    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= 1'b0;
        cfg_data  <= '0;
        size_x = 31'h0001_0000;
        size_y = 31'h0001_0000;
        clear_sums();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_size_sweep();
        test_random_sets();
        test_backpressure();

        s_tvalid <= 1'b0;
        while (pending_rates.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS shallow_water_cell_rate");
        end else begin
            $display("FAIL shallow_water_cell_rate");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/swcr_pkg.sv
sv/swcr_div.sv
sv/shallow_water_cell_rate.sv
tb/shallow_water_cell_rate_tb.sv
